[sv/lj_pkg.sv]
// Shared types, constants and helper functions of the Lennard-Jones pair force block.
// No dependencies; every other file in the project imports this package.
package lj_pkg;

  localparam int MAX_ATOMS = 1024;
  localparam int ATOM_W    = $clog2(MAX_ATOMS);
  localparam int POS_W     = 32;
  localparam int COEFF_W   = 48;
  localparam int OUT_W     = 48;
  localparam int DSQ_W     = 50;
  localparam int IN_DATA_W = ((2 * ATOM_W + 6 * POS_W + 2 * COEFF_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * ATOM_W + 5 * OUT_W + 7) / 8) * 8;

  // Right-shift codes of the shared multiplier.
  localparam logic [2:0] SH_0  = 3'd0;
  localparam logic [2:0] SH_16 = 3'd1;
  localparam logic [2:0] SH_24 = 3'd2;
  localparam logic [2:0] SH_30 = 3'd3;
  localparam logic [2:0] SH_46 = 3'd4;

  localparam logic [OUT_W-1:0] POS48 = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG48 = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic       start;
    logic [2:0] shift;
  } lj_mul_req_t;

  // Sign times (a - b), saturated to the signed 48-bit range.
  function automatic logic [OUT_W-1:0] signed_diff48(input logic [63:0] a,
                                                    input logic [63:0] b,
                                                    input logic neg_sign);
    logic [63:0] mag;
    logic        n;
    logic [63:0] m;
    if (a >= b) begin
      mag = a - b;
      n   = neg_sign;
    end else begin
      mag = b - a;
      n   = !neg_sign;
    end
    if (n) begin
      m = (mag > {16'd0, NEG48}) ? {16'd0, NEG48} : mag;
      signed_diff48 = OUT_W'(64'd0 - m);
    end else begin
      signed_diff48 = (mag > {16'd0, POS48}) ? POS48 : mag[OUT_W-1:0];
    end
  endfunction

endpackage

[sv/lj_mul.sv]
// Shared 64x64 multiplier built from one 32x32 multiplier over four passes,
// with a selectable right shift and saturation to 64 bits. Depends on lj_pkg.
module lj_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  lj_pkg::lj_mul_req_t req,
  input  logic [63:0]        a,
  input  logic [63:0]        b,
  output logic               done,
  output logic [63:0]        res
);
  import lj_pkg::*;

  logic [63:0]  a_r, b_r, p_r;
  logic [2:0]   sh_r;
  logic [2:0]   cnt_r;
  logic [1:0]   pk_r;
  logic         busy_r, done_r;
  logic [127:0] acc_r, acc_nxt, p_ext;
  logic [31:0]  opa, opb;
  logic         sat;

  always_comb begin
    opa = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    opb = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    p_ext = {64'd0, p_r};
    case (pk_r)
      2'd0:    acc_nxt = acc_r + p_ext;
      2'd3:    acc_nxt = acc_r + (p_ext << 64);
      default: acc_nxt = acc_r + (p_ext << 32);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= a;
        b_r    <= b;
        sh_r   <= req.shift;
        acc_r  <= 128'd0;
        cnt_r  <= 3'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r < 3'd4) begin
          p_r  <= opa * opb;
          pk_r <= cnt_r[1:0];
        end
        if (cnt_r != 3'd0) begin
          acc_r <= acc_nxt;
        end
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_comb begin
    case (sh_r)
      SH_16: begin
        sat = |acc_r[127:80];
        res = acc_r[79:16];
      end
      SH_24: begin
        sat = |acc_r[127:88];
        res = acc_r[87:24];
      end
      SH_30: begin
        sat = |acc_r[127:94];
        res = acc_r[93:30];
      end
      SH_46: begin
        sat = |acc_r[127:110];
        res = acc_r[109:46];
      end
      default: begin
        sat = |acc_r[127:64];
        res = acc_r[63:0];
      end
    endcase
    if (sat) begin
      res = {64{1'b1}};
    end
  end

  assign done = done_r;

endmodule

[sv/lennard_jones_pair_force.sv]
// Top level of the Lennard-Jones 12-6 pair force and energy block.
// Depends on lj_pkg and on the shared multiplier lj_mul.
//
// Usage. One atom pair enters per transfer on the in_ channel: both atom
// indices, both positions (signed Q7.24 nm), C6 and C12 (40 fraction bits),
// with in_tlast marking the final pair of a list. One result leaves per pair
// on the out_ channel: the indices, the force on the first atom, the pair
// energy and, on the last pair, the list energy total, which is flagged by
// out_tlast; out_tuser flags coincident positions (force and energy zero).
// Sequence. Between a pair's transfer and its result, a 63-step restoring
// divider forms r^-2, one quotient bit a cycle, and eighteen products run one
// after another through the single 32x32 multiplier. One pair is in work at
// a time, so in_tready is low from the accepting transfer until the result
// has been written into the output register.
// Reset clears the sequencer, the output register's valid flag and the
// running energy total. If the receiver stalls, the finished result waits in
// the output register, and a following pair's result waits inside the block
// until the register has been emptied; nothing is dropped.
module lennard_jones_pair_force (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // first_atom, second_atom, first_x, first_y, first_z, second_x, second_y,
  // second_z, disp_coeff, rep_coeff, then zero padding
  input  logic [lj_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                          in_tlast,   // last_pair
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_first_atom, out_second_atom, force_x, force_y, force_z,
  // pair_energy, total_energy, then zero padding
  output logic [lj_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast,  // total_valid
  output logic                          out_tuser   // zero_distance
);
  import lj_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  localparam logic [4:0] STEP_LAST_SQ = 5'd2;
  localparam logic [4:0] STEP_FORCE   = 5'd12;
  localparam logic [4:0] STEP_END     = 5'd17;
  localparam logic [5:0] DIV_TOP      = 6'd62;

  logic [2:0]        state_r;
  logic [4:0]        step_r;
  logic              issued_r;
  logic [ATOM_W-1:0] atom1_r, atom2_r;
  logic [31:0]       ad_r [3];
  logic [2:0]        neg_r;
  logic              zero_r, last_r;
  logic [63:0]       c6_r, c12_r;
  logic [DSQ_W-1:0]  dsq_r;
  logic [DSQ_W:0]    rem_r;
  logic [62:0]       q_r;
  logic [5:0]        div_cnt_r;
  logic [63:0]       r2_r, t_r, r6_r, r12_r, ed_r, er_r, fa_r, fb_r;
  logic [OUT_W-1:0]  f_r [3];
  logic [63:0]       esum_r;

  logic              out_valid_r, out_last_r, out_zero_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Difference vector of the incoming pair: magnitudes and signs.
  logic [32:0] d_in [3];
  logic [31:0] ad_in [3];
  always_comb begin
    for (int m = 0; m < 3; m++) begin
      d_in[m] = {in_tdata[2*ATOM_W + 32*m + 31], in_tdata[2*ATOM_W + 32*m +: 32]}
              - {in_tdata[2*ATOM_W + 96 + 32*m + 31], in_tdata[2*ATOM_W + 96 + 32*m +: 32]};
      ad_in[m] = d_in[m][32] ? 32'(33'd0 - d_in[m]) : d_in[m][31:0];
    end
  end

  // Operand selection for the shared multiplier.
  lj_mul_req_t mul_req;
  logic [63:0] mul_a, mul_b, mul_res;
  logic        mul_done;
  logic [4:0]  fstep;
  logic [1:0]  fm;

  always_comb begin
    fstep = step_r - STEP_FORCE;
    fm    = fstep[2:1];
    mul_req.start = (state_r == S_MUL) && !issued_r;
    mul_req.shift = SH_30;
    mul_a = r2_r;
    mul_b = r2_r;
    case (step_r)
      5'd0, 5'd1, 5'd2: begin
        mul_a = {32'd0, ad_r[step_r[1:0]]};
        mul_b = {32'd0, ad_r[step_r[1:0]]};
        mul_req.shift = SH_16;
      end
      5'd3: begin
        mul_a = r2_r;
        mul_b = r2_r;
      end
      5'd4: begin
        mul_a = t_r;
        mul_b = r2_r;
      end
      5'd5: begin
        mul_a = r6_r;
        mul_b = r6_r;
      end
      5'd6: begin
        mul_a = c6_r;
        mul_b = r6_r;
        mul_req.shift = SH_46;
      end
      5'd7: begin
        mul_a = c12_r;
        mul_b = r12_r;
        mul_req.shift = SH_46;
      end
      5'd8: begin
        mul_a = er_r;
        mul_b = 64'd12;
        mul_req.shift = SH_0;
      end
      5'd9: begin
        mul_a = ed_r;
        mul_b = 64'd6;
        mul_req.shift = SH_0;
      end
      5'd10: begin
        mul_a = t_r;
        mul_b = r2_r;
      end
      5'd11: begin
        mul_a = r12_r;
        mul_b = r2_r;
      end
      default: begin
        mul_a = fstep[0] ? fb_r : fa_r;
        mul_b = {32'd0, ad_r[fm]};
        mul_req.shift = SH_24;
      end
    endcase
  end

  lj_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mul_res)
  );

  // Divider step and squared-distance accumulation.
  logic [DSQ_W:0]   rem_sh;
  logic             q_bit;
  logic [DSQ_W-1:0] dsq_sum;
  always_comb begin
    rem_sh = {rem_r[DSQ_W-1:0], (div_cnt_r == DIV_TOP)};
    q_bit  = rem_sh >= {1'b0, dsq_r};
    dsq_sum = dsq_r + mul_res[DSQ_W-1:0];
  end

  // Result assembly and saturating energy total.
  logic [OUT_W-1:0] epair;
  logic [64:0]      sum_ext;
  logic [63:0]      esum_new;
  logic [OUT_W-1:0] total;
  logic             load_out;
  always_comb begin
    epair = zero_r ? '0 : signed_diff48(er_r, ed_r, 1'b0);
    sum_ext = {esum_r[63], esum_r} + {{17{epair[OUT_W-1]}}, epair};
    if (sum_ext[64] != sum_ext[63]) begin
      esum_new = sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      esum_new = sum_ext[63:0];
    end
    if (esum_new[63:OUT_W-1] == '0 || esum_new[63:OUT_W-1] == '1) begin
      total = esum_new[OUT_W-1:0];
    end else begin
      total = esum_new[63] ? NEG48 : POS48;
    end
    load_out = (state_r == S_FIN) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 5'd0;
      issued_r    <= 1'b0;
      esum_r      <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            atom1_r <= in_tdata[ATOM_W-1:0];
            atom2_r <= in_tdata[2*ATOM_W-1:ATOM_W];
            for (int m = 0; m < 3; m++) begin
              ad_r[m]  <= ad_in[m];
              neg_r[m] <= d_in[m][32];
            end
            zero_r   <= (ad_in[0] | ad_in[1] | ad_in[2]) == 32'd0;
            c6_r     <= {16'd0, in_tdata[2*ATOM_W + 192 +: COEFF_W]};
            c12_r    <= {16'd0, in_tdata[2*ATOM_W + 192 + COEFF_W +: COEFF_W]};
            last_r   <= in_tlast;
            dsq_r    <= '0;
            step_r   <= 5'd0;
            issued_r <= 1'b0;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_req.start) begin
            issued_r <= 1'b1;
          end
          if (mul_done) begin
            issued_r <= 1'b0;
            step_r   <= step_r + 5'd1;
            case (step_r)
              5'd0, 5'd1: dsq_r <= dsq_sum;
              5'd2: begin
                dsq_r <= (dsq_sum == '0) ? DSQ_W'(1) : dsq_sum;
              end
              5'd3: t_r <= mul_res;
              5'd4: r6_r <= mul_res;
              5'd5: r12_r <= mul_res;
              5'd6: ed_r <= mul_res;
              5'd7: er_r <= mul_res;
              5'd8: t_r <= mul_res;
              5'd9: r12_r <= mul_res;
              5'd10: fa_r <= mul_res;
              5'd11: fb_r <= mul_res;
              default: begin
                if (!fstep[0]) begin
                  t_r <= mul_res;
                end else begin
                  f_r[fm] <= signed_diff48(t_r, mul_res, neg_r[fm]);
                end
              end
            endcase
            if (step_r == STEP_LAST_SQ) begin
              if (zero_r) begin
                state_r <= S_FIN;
              end else begin
                rem_r     <= '0;
                q_r       <= '0;
                div_cnt_r <= DIV_TOP;
                state_r   <= S_DIV;
              end
            end else if (step_r == STEP_END) begin
              state_r <= S_FIN;
            end
          end
        end
        S_DIV: begin
          rem_r     <= q_bit ? (rem_sh - {1'b0, dsq_r}) : rem_sh;
          q_r       <= {q_r[61:0], q_bit};
          div_cnt_r <= div_cnt_r - 6'd1;
          if (div_cnt_r == 6'd0) begin
            r2_r    <= {1'b0, q_r[61:0], q_bit};
            state_r <= S_MUL;
          end
        end
        S_FIN: begin
          if (load_out) begin
            out_valid_r <= 1'b1;
            out_last_r  <= last_r;
            out_zero_r  <= zero_r;
            out_data_r  <= OUT_DATA_W'({
              last_r ? total : '0,
              epair,
              zero_r ? '0 : f_r[2],
              zero_r ? '0 : f_r[1],
              zero_r ? '0 : f_r[0],
              atom2_r,
              atom1_r});
            esum_r  <= last_r ? 64'd0 : esum_new;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_zero_r;

endmodule

[sv/lj_checker.sv]
// Port-level checker for the Lennard-Jones pair force block, with its bind.
// Depends on lj_pkg for the channel widths.
module lj_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [lj_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                          in_tlast,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [lj_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                          out_tlast,
  input logic                          out_tuser
);
  import lj_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // One pair in work at a time: after a transfer in, the block is busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a pair is in work");

  // Coincident positions give zero force and zero pair energy.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2*ATOM_W + 4*OUT_W - 1:2*ATOM_W] == '0)
    else $error("non-zero force or energy at zero distance");

  // The total is only shown on the last pair of a list.
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[2*ATOM_W + 5*OUT_W - 1:2*ATOM_W + 4*OUT_W] == '0)
    else $error("energy total shown before the last pair");

endmodule

bind lennard_jones_pair_force lj_checker u_lj_checker (.*);
